// ===== design/assert_macros.svh =====
// Concurrent check helpers. Every check is sampled on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

    localparam int HEAP_SLOTS = 64;
    localparam int ADDR_W     = $clog2(HEAP_SLOTS);
    localparam int ENTRY_W    = 32;
    localparam int COUNT_W    = 6;
    localparam int HEAP_CAP   = ((HEAP_SLOTS - 1) < 63) ? (HEAP_SLOTS - 1) : 63;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [ADDR_W:0]    child_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LOAD,
        ST_DOWN,
        ST_FINISH
    } state_t;

endpackage

// ===== design/mhpq_ram.sv =====
module mhpq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read on both ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== design/min_heap_priority_queue_core.sv =====
// Binary min-heap priority queue. Entries are ordered by arrival time, then thread
// number, then process number, and live in a dual-read single-write RAM at slots 1
// to count. One request is processed at a time. An insert climbs in UP while the
// parent is greater and drops its entry into the hole in FINISH; an insert into an
// empty heap goes straight to FINISH. A remove reads the root and the last entry
// in LOAD, sinks the moved entry in DOWN and writes it in FINISH. A peek goes
// through LOAD to FINISH, and a rejected or ignored request goes straight to
// FINISH. A finished result waits in an output register, so the next request is
// accepted while the previous result is still unclaimed. A second result that
// finds that register still full holds in FINISH until it drains.
`include "assert_macros.svh"

module min_heap_priority_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  action,
    input  logic [15:0] arrival_time,
    input  logic [7:0]  thread_number,
    input  logic [7:0]  process_number,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [15:0] out_arrival_time,
    output logic [7:0]  out_thread_number,
    output logic [7:0]  out_process_number,
    output logic [5:0]  count
);

    import mhpq_pkg::*;

    state_t     state_reg, state_next;
    count_t     count_reg, count_next;
    addr_t      pos_reg, pos_next;        // current hole position during a sift
    entry_t     cur_reg, cur_next;        // entry being sifted
    entry_t     shown_reg, shown_next;    // entry reported by remove or peek
    logic [1:0] stat_reg, stat_next;
    logic       remove_reg, remove_next;  // LOAD follows a remove, not a peek
    logic       wfin_reg, wfin_next;      // FINISH must drop cur into the hole

    logic       res_valid_reg, res_valid_next;
    logic [1:0] res_status_reg, res_status_next;
    entry_t     res_entry_reg, res_entry_next;
    count_t     res_count_reg, res_count_next;

    logic       ram_we;
    addr_t      ram_waddr, ram_raddr_a, ram_raddr_b;
    entry_t     ram_wdata, ram_rdata_a, ram_rdata_b;

    entry_t     req_entry;
    logic       heap_full, heap_empty, out_free;
    count_t     count_up;
    addr_t      ins_pos, up_par;
    logic       up_move;
    child_t     dn_left, dn_right, count_ext;
    logic       take_l, take_r, dn_move;
    entry_t     l_best_val, dn_val;
    addr_t      dn_best;
    logic       ins_accept, waddr_live;

    mhpq_ram #(
        .DEPTH(HEAP_SLOTS),
        .WIDTH(ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Packed key compares as one unsigned word in lexicographic order.
    assign req_entry  = {arrival_time, thread_number, process_number};
    assign heap_full  = (count_reg >= COUNT_W'(HEAP_CAP));
    assign heap_empty = (count_reg == '0);
    assign out_free   = !res_valid_reg || res_ready;
    assign req_ready  = (state_reg == ST_IDLE);

    // Sift-up: the parent of the hole sits on read port A.
    assign count_up = count_reg + count_t'(1);
    assign ins_pos  = addr_t'(count_up);
    assign up_par   = pos_reg >> 1;
    assign up_move  = (ram_rdata_a > cur_reg);

    // Sift-down: left child on port A, right child on port B. Ties go left.
    assign count_ext  = child_t'(count_reg);
    assign dn_left    = {pos_reg, 1'b0};
    assign dn_right   = {pos_reg, 1'b1};
    assign take_l     = (dn_left <= count_ext) && (ram_rdata_a < cur_reg);
    assign l_best_val = take_l ? ram_rdata_a : cur_reg;
    assign take_r     = (dn_right <= count_ext) && (ram_rdata_b < l_best_val);
    assign dn_move    = take_l || take_r;
    assign dn_val     = take_r ? ram_rdata_b : ram_rdata_a;
    assign dn_best    = take_r ? addr_t'(dn_right) : addr_t'(dn_left);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (action)
                        ACT_INSERT:
                        begin
                            if (heap_full || heap_empty)
                                state_next = ST_FINISH;
                            else
                                state_next = ST_UP;
                        end
                        ACT_REMOVE, ACT_PEEK:
                        begin
                            if (heap_empty)
                                state_next = ST_FINISH;
                            else
                                state_next = ST_LOAD;
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_UP:
            begin
                if (up_move && (up_par != addr_t'(1)))
                    state_next = ST_UP;
                else
                    state_next = ST_FINISH;
            end
            ST_LOAD:
            begin
                if (remove_reg && (count_reg != count_t'(1)))
                    state_next = ST_DOWN;
                else
                    state_next = ST_FINISH;
            end
            ST_DOWN:
            begin
                if (dn_move)
                    state_next = ST_DOWN;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        shown_next      = shown_reg;
        stat_next       = stat_reg;
        remove_next     = remove_reg;
        wfin_next       = wfin_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_count_next  = res_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = cur_reg;
        ram_raddr_a     = up_par;
        ram_raddr_b     = pos_reg;

        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Fetch parent of the new slot, or root and last entry.
                ram_raddr_a = (action == ACT_INSERT) ? (ins_pos >> 1) : addr_t'(1);
                ram_raddr_b = addr_t'(count_reg);
                if (req_valid)
                begin
                    stat_next   = STAT_OK;
                    shown_next  = '0;
                    wfin_next   = 1'b0;
                    remove_next = (action == ACT_REMOVE);
                    case (action)
                        ACT_INSERT:
                        begin
                            if (heap_full)
                            begin
                                stat_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_up;
                                pos_next   = ins_pos;
                                cur_next   = req_entry;
                                wfin_next  = 1'b1;
                            end
                        end
                        ACT_REMOVE, ACT_PEEK:
                        begin
                            if (heap_empty)
                                stat_next = STAT_EMPTY;
                        end
                        default: stat_next = STAT_OK;
                    endcase
                end
            end
            ST_UP:
            begin
                ram_raddr_a = up_par >> 1;
                if (up_move)
                begin
                    // Pull the parent down into the hole and climb.
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata_a;
                    pos_next  = up_par;
                end
            end
            ST_LOAD:
            begin
                shown_next  = ram_rdata_a;
                ram_raddr_a = addr_t'(2);
                ram_raddr_b = addr_t'(3);
                if (remove_reg)
                begin
                    count_next = count_reg - count_t'(1);
                    cur_next   = ram_rdata_b;
                    pos_next   = addr_t'(1);
                    wfin_next  = (count_reg != count_t'(1));
                end
            end
            ST_DOWN:
            begin
                ram_raddr_a = addr_t'({dn_best, 1'b0});
                ram_raddr_b = addr_t'({dn_best, 1'b1});
                if (dn_move)
                begin
                    // Lift the smaller child into the hole and descend.
                    ram_we    = 1'b1;
                    ram_wdata = dn_val;
                    pos_next  = dn_best;
                end
            end
            ST_FINISH:
            begin
                ram_we = wfin_reg;
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_entry_next  = shown_reg;
                    res_count_next  = count_reg;
                end
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload, no reset needed.
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        shown_reg      <= shown_next;
        stat_reg       <= stat_next;
        remove_reg     <= remove_next;
        wfin_reg       <= wfin_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        res_count_reg  <= res_count_next;
    end

    assign res_valid          = res_valid_reg;
    assign status             = res_status_reg;
    assign out_arrival_time   = res_entry_reg[31:16];
    assign out_thread_number  = res_entry_reg[15:8];
    assign out_process_number = res_entry_reg[7:0];
    assign count              = res_count_reg;

    assign ins_accept = req_valid && req_ready && (action == ACT_INSERT) && !heap_full;
    assign waddr_live = (ram_waddr != '0) && (child_t'(ram_waddr) <= count_ext);

    `CHK_IMPLY(a_count_cap, 1'b1, count_reg <= COUNT_W'(HEAP_CAP), "count above capacity")
    `CHK_IMPLY(a_write_in_heap, ram_we, waddr_live, "write outside live slots")
    `CHK_NEXT(a_insert_grows, ins_accept, count_reg == $past(count_up), "count did not grow")
    `CHK_IMPLY(a_result_from_finish, $rose(res_valid_reg), $past(state_reg) == ST_FINISH, "result raised outside finish")

endmodule

// ===== verif/min_heap_priority_queue_core_tb.sv =====
module min_heap_priority_queue_core_tb;

    import mhpq_pkg::*;

    // Action code 3 has no package name; the block ignores it but still answers.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 950;
    // No new idle gaps start on either side once this few requests remain.
    localparam int QUIET_TAIL   = 100;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [1:0] act;
        entry_t     key;
    } heap_request_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] arrival;
        logic [7:0]  thread;
        logic [7:0]  process;
        logic [5:0]  cnt;
    } heap_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  action = ACT_INSERT;
    logic [15:0] arrival_time = 16'd0;
    logic [7:0]  thread_number = 8'd0;
    logic [7:0]  process_number = 8'd0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] out_arrival_time;
    logic [7:0]  out_thread_number;
    logic [7:0]  out_process_number;
    logic [5:0]  count;

    // Predicted heap contents, slots 1 to heap_cnt.
    entry_t      heap_mem [HEAP_SLOTS];
    int unsigned heap_cnt = 0;

    heap_request_t pending_requests [$];
    heap_result_t  expected_results [$];

    logic req_taken = 1'b0;
    int   req_gap = 0;
    int   res_gap = 0;
    int   requests_taken = 0;
    int   total_requests = 0;
    int   fail_count = 0;
    int   cycle_count = 0;

    min_heap_priority_queue_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_ready          (req_ready),
        .action             (action),
        .arrival_time       (arrival_time),
        .thread_number      (thread_number),
        .process_number     (process_number),
        .res_valid          (res_valid),
        .res_ready          (res_ready),
        .status             (status),
        .out_arrival_time   (out_arrival_time),
        .out_thread_number  (out_thread_number),
        .out_process_number (out_process_number),
        .count              (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predicted heap and return the result it must produce.
    // The packed word order (arrival, thread, process) compared unsigned is the
    // priority order, so plain vector compares do the lexicographic tie-breaking.
    function automatic heap_result_t predict_request(logic [1:0] act, entry_t key);
        heap_result_t r;
        entry_t       shown;
        entry_t       tmp;
        int unsigned  pos;
        int unsigned  lft;
        int unsigned  best;
        bit           done;
        r.status = STAT_OK;
        shown = '0;
        if (act == ACT_INSERT)
        begin
            if (heap_cnt >= HEAP_CAP)
                r.status = STAT_FULL;
            else
            begin
                // Append at the end, then climb while the parent is strictly greater.
                heap_cnt++;
                heap_mem[heap_cnt] = key;
                pos = heap_cnt;
                done = 1'b0;
                while (pos > 1 && !done)
                begin
                    if (heap_mem[pos >> 1] > heap_mem[pos])
                    begin
                        tmp = heap_mem[pos >> 1];
                        heap_mem[pos >> 1] = heap_mem[pos];
                        heap_mem[pos] = tmp;
                        pos = pos >> 1;
                    end
                    else
                        done = 1'b1;
                end
            end
        end
        else if (act == ACT_REMOVE || act == ACT_PEEK)
        begin
            if (heap_cnt == 0)
                r.status = STAT_EMPTY;
            else
            begin
                shown = heap_mem[1];
                if (act == ACT_REMOVE)
                begin
                    // Move the last entry to the root and sink it toward the
                    // smaller child; the left child wins a tie.
                    heap_mem[1] = heap_mem[heap_cnt];
                    heap_cnt--;
                    pos = 1;
                    done = 1'b0;
                    while (!done)
                    begin
                        lft = pos * 2;
                        best = pos;
                        if (lft <= heap_cnt && heap_mem[lft] < heap_mem[best])
                            best = lft;
                        if (lft + 1 <= heap_cnt && heap_mem[lft + 1] < heap_mem[best])
                            best = lft + 1;
                        if (best == pos)
                            done = 1'b1;
                        else
                        begin
                            tmp = heap_mem[pos];
                            heap_mem[pos] = heap_mem[best];
                            heap_mem[best] = tmp;
                            pos = best;
                        end
                    end
                end
            end
        end
        r.arrival = shown[31:16];
        r.thread  = shown[15:8];
        r.process = shown[7:0];
        r.cnt     = heap_cnt[5:0];
        return r;
    endfunction

    function automatic heap_request_t make_request(logic [1:0] act, logic [15:0] arr,
                                                   logic [7:0] thr, logic [7:0] prc);
        heap_request_t q;
        q.act = act;
        q.key = {arr, thr, prc};
        return q;
    endfunction

    // Half the keys are fully random; the other half come from a narrow set so that
    // equal arrival times and equal threads show up often and exercise tie-breaking.
    function automatic entry_t pick_key();
        entry_t k;
        if ($urandom_range(0, 1) == 0)
            k = $urandom();
        else
        begin
            k[31:16] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2));
            k[15:8]  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 2));
            k[7:0]   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 2));
        end
        return k;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: present the next pending request at the falling edge once the
    // current one was taken, with occasional random gaps between requests.
    always @(negedge clk)
    begin
        heap_request_t nxt;
        if (rst_n && (!req_valid || req_taken))
        begin
            if (req_gap != 0)
            begin
                req_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end
            else if (pending_requests.size() != 0)
            begin
                nxt = pending_requests.pop_front();
                action         <= nxt.act;
                arrival_time   <= nxt.key[31:16];
                thread_number  <= nxt.key[15:8];
                process_number <= nxt.key[7:0];
                req_valid      <= 1'b1;
                if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                    req_gap <= $urandom_range(1, 10);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Result side back-pressure: hold ready low for random bursts, none near the end.
    always @(negedge clk)
    begin
        if (res_gap != 0)
        begin
            res_ready <= 1'b0;
            res_gap <= res_gap - 1;
        end
        else
        begin
            res_ready <= 1'b1;
            if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
                res_gap <= $urandom_range(1, 10);
        end
    end

    // Monitor: predict on every accepted request, check every accepted result
    // against the oldest prediction, and stop the run on a timeout.
    always @(posedge clk)
    begin
        heap_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("min_heap_priority_queue_core regression: fail");
            $finish;
        end
        else
        begin
            req_taken <= req_valid && req_ready;
            if (req_valid && req_ready)
            begin
                expected_results.push_back(predict_request(action,
                    {arrival_time, thread_number, process_number}));
                requests_taken++;
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("out_arrival_time", want.arrival, out_arrival_time);
                    check_field("out_thread_number", want.thread, out_thread_number);
                    check_field("out_process_number", want.process, out_process_number);
                    check_field("count", want.cnt, count);
                end
            end
        end
    end

    initial
    begin
        int          seg_left;
        int          mode;
        int unsigned pick;
        logic [1:0]  act;
        entry_t      key;

        foreach (heap_mem[i])
            heap_mem[i] = '0;

        // Directed part: empty cases, extreme keys, ties on each key, the unused
        // action, then drain past empty.
        pending_requests.push_back(make_request(ACT_PEEK, 16'h0000, 8'h00, 8'h00));
        pending_requests.push_back(make_request(ACT_REMOVE, 16'hFFFF, 8'hFF, 8'hFF));
        pending_requests.push_back(make_request(ACT_UNUSED, 16'hFFFF, 8'hFF, 8'hFF));
        pending_requests.push_back(make_request(ACT_INSERT, 16'hFFFF, 8'hFF, 8'hFF));
        pending_requests.push_back(make_request(ACT_PEEK, 16'h0000, 8'h00, 8'h00));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h0000, 8'h00, 8'h00));
        pending_requests.push_back(make_request(ACT_PEEK, 16'hFFFF, 8'hFF, 8'hFF));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h1234, 8'h05, 8'h06));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h1234, 8'h05, 8'h05));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h1234, 8'h04, 8'hC8));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h1233, 8'hFF, 8'hFF));
        pending_requests.push_back(make_request(ACT_INSERT, 16'h1234, 8'h05, 8'h06));
        pending_requests.push_back(make_request(ACT_UNUSED, 16'h5A5A, 8'hA5, 8'h3C));
        for (int i = 0; i < 8; i++)
            pending_requests.push_back(make_request(ACT_REMOVE, 16'h0000, 8'h00, 8'h00));
        pending_requests.push_back(make_request(ACT_PEEK, 16'h0000, 8'h00, 8'h00));

        // Random part in segments: fill (drives the heap to full and into dropped
        // inserts), drain (runs it down to empty), and a balanced mix.
        seg_left = 0;
        mode = 2;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (seg_left == 0)
            begin
                mode = (mode + 1) % 3;
                seg_left = $urandom_range(60, 130);
            end
            seg_left--;
            pick = $urandom_range(0, 99);
            if (pick >= 98)
                act = ACT_UNUSED;
            else if (mode == 0)
                act = (pick < 80) ? ACT_INSERT : (pick < 92) ? ACT_REMOVE : ACT_PEEK;
            else if (mode == 1)
                act = (pick < 15) ? ACT_INSERT : (pick < 85) ? ACT_REMOVE : ACT_PEEK;
            else
                act = (pick < 45) ? ACT_INSERT : (pick < 80) ? ACT_REMOVE : ACT_PEEK;
            key = pick_key();
            pending_requests.push_back(make_request(act, key[31:16], key[15:8], key[7:0]));
        end
        total_requests = pending_requests.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every request to be taken and every result to be claimed.
        while (requests_taken < total_requests || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("min_heap_priority_queue_core regression: pass");
        else
            $display("min_heap_priority_queue_core regression: fail");
        $finish;
    end

endmodule
